// ===== src/dhtm_pkg.sv =====
// Shared types and constants for the device heartbeat timeout monitor.
package dhtm_pkg;

	localparam int DEV_MAX = 8;
	localparam int DEV_W   = 3;

	// Configuration register indexes.
	localparam logic [2:0] REG_OFFLINE_LO = 3'd0;
	localparam logic [2:0] REG_OFFLINE_HI = 3'd1;
	localparam logic [2:0] REG_ONLINE_LO  = 3'd2;
	localparam logic [2:0] REG_ONLINE_HI  = 3'd3;
	localparam logic [2:0] REG_PRIORITY   = 3'd4;
	localparam logic [2:0] REG_ENABLE     = 3'd5;

	// Request types.
	localparam logic REQ_BEAT = 1'b0;
	localparam logic REQ_SCAN = 1'b1;

	localparam logic [3:0] NO_DEV = 4'd8;

	localparam logic [63:0] OFFLINE_LO_RST = 64'd14073963616665610;
	localparam logic [63:0] OFFLINE_HI_RST = 64'd70369817935872250;
	localparam logic [63:0] ONLINE_LO_RST  = 64'd14073963616665610;
	localparam logic [63:0] ONLINE_HI_RST  = 64'd70369817935872250;
	localparam logic [31:0] PRIORITY_RST   = 32'd286365722;
	localparam logic [7:0]  ENABLE_RST     = 8'hFF;

	typedef struct packed {
		logic             load;
		logic             beat;
		logic             scan_step;
		logic             scan_last;
		logic             out_load;
		logic [DEV_W-1:0] idx;
	} dhtm_cmd_t;

endpackage

// ===== src/device_heartbeat_timeout_monitor.sv =====
// Heartbeat item: the beat state, then the completion state, which loads the result.
// Scan item: one device per cycle in the scan state, then the completion state.
// The completion state waits while the output stalls; the next item is taken in idle.
// The scan rate is set by the single shared classifier that visits one device a cycle.
// A new item is taken while the previous result still waits in the output register.
// Reset clears time stamps to zero, sets lost, error and data-error flags, and
// loads the default limits, priorities and enable mask; no clearing pass is needed.
module device_heartbeat_timeout_monitor #(
	parameter int DEVICES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [2:0]  device,
	input  logic [31:0] now,
	input  logic        data_bad,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        device_error,
	output logic [7:0]  lost_mask,
	output logic [7:0]  error_mask,
	output logic        any_offline,
	output logic [3:0]  top_device,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import dhtm_pkg::*;

	dhtm_cmd_t cmd;

	assign cfg_ready = 1'b1;

	dhtm_ctrl #(
		.DEVICES (DEVICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dhtm_datapath #(
		.DEVICES (DEVICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.device       (device),
		.now          (now),
		.data_bad     (data_bad),
		.device_error (device_error),
		.lost_mask    (lost_mask),
		.error_mask   (error_mask),
		.any_offline  (any_offline),
		.top_device   (top_device)
	);

endmodule

// ===== src/dhtm_ctrl.sv =====
// Controller state machine: item sequencing, scan index and output valid.
module dhtm_ctrl #(
	parameter int DEVICES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	output logic                out_valid,
	input  logic                out_stall,
	output dhtm_pkg::dhtm_cmd_t cmd
);
	import dhtm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BEAT = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [DEV_W-1:0] LAST_IDX = DEV_W'(DEVICES - 1);

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [DEV_W-1:0] idx_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.idx       = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = (req_type == REQ_SCAN) ? ST_SCAN : ST_BEAT;
				end
			end
			ST_BEAT: begin
				cmd.beat = 1'b1;
				state_d  = ST_DONE;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (idx_q == LAST_IDX) begin
					cmd.scan_last = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan_step && !cmd.scan_last) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result loaded over an untaken result");

	a_scan_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && idx_q != LAST_IDX) |=>
		(state_q == ST_SCAN && idx_q == $past(idx_q) + 1'b1))
		else $error("scan skipped or repeated a device");

	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_BEAT || state_q == ST_SCAN))
		else $error("accepted item was not dispatched");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result valid raised outside the completion state");

endmodule

// ===== src/dhtm_datapath.sv =====
// Datapath: configuration, per-device time stamps and flags, scan and result registers.
module dhtm_datapath #(
	parameter int DEVICES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dhtm_pkg::dhtm_cmd_t cmd,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic [2:0]          device,
	input  logic [31:0]         now,
	input  logic                data_bad,
	output logic                device_error,
	output logic [7:0]          lost_mask,
	output logic [7:0]          error_mask,
	output logic                any_offline,
	output logic [3:0]          top_device
);
	import dhtm_pkg::*;

	localparam logic [DEV_MAX-1:0] DEV_MASK = DEV_MAX'((1 << DEVICES) - 1);
	localparam logic [3:0]         DEV_LIM  = 4'(DEVICES);

	logic [63:0]        off_lo_q, off_hi_q, on_lo_q, on_hi_q;
	logic [31:0]        prio_q;
	logic [DEV_MAX-1:0] enable_q;

	logic [31:0]        beat_q   [DEV_MAX];
	logic [31:0]        online_q [DEV_MAX];
	logic [DEV_MAX-1:0] lost_q, err_q, derr_q;

	logic [DEV_W-1:0]   dev_q;
	logic [31:0]        now_q;
	logic               bad_q;
	logic               dev_ok;

	logic [3:0]         best_q, top_q, scan_top_q;
	logic               any_q, scan_any_q;

	logic [63:0]        off_word, on_word;
	logic [15:0]        off_lim, on_lim;
	logic [3:0]         pri;
	logic               en, offline, settling;
	logic [3:0]         best_n, top_n;
	logic               any_n;

	logic               dev_err_q;
	logic [7:0]         lost_out_q, err_out_q;
	logic               any_out_q;
	logic [3:0]         top_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_lo_q <= OFFLINE_LO_RST;
			off_hi_q <= OFFLINE_HI_RST;
			on_lo_q  <= ONLINE_LO_RST;
			on_hi_q  <= ONLINE_HI_RST;
			prio_q   <= PRIORITY_RST;
			enable_q <= ENABLE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OFFLINE_LO: off_lo_q <= cfg_data;
				REG_OFFLINE_HI: off_hi_q <= cfg_data;
				REG_ONLINE_LO:  on_lo_q  <= cfg_data;
				REG_ONLINE_HI:  on_hi_q  <= cfg_data;
				REG_PRIORITY:   prio_q   <= cfg_data[31:0];
				REG_ENABLE:     enable_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dev_q <= device;
			now_q <= now;
			bad_q <= data_bad;
		end
	end

	assign dev_ok = ({1'b0, dev_q} < DEV_LIM);

	// One device is classified per scan step.
	assign off_word = cmd.idx[2] ? off_hi_q : off_lo_q;
	assign on_word  = cmd.idx[2] ? on_hi_q : on_lo_q;
	assign off_lim  = off_word[{cmd.idx[1:0], 4'b0000} +: 16];
	assign on_lim   = on_word[{cmd.idx[1:0], 4'b0000} +: 16];
	assign pri      = prio_q[{cmd.idx, 2'b00} +: 4];
	assign en       = enable_q[cmd.idx];
	assign offline  = (now_q - beat_q[cmd.idx]) > {16'b0, off_lim};
	assign settling = (now_q - online_q[cmd.idx]) < {16'b0, on_lim};

	always_comb begin
		best_n = best_q;
		top_n  = top_q;
		any_n  = any_q;
		if (en && offline) begin
			any_n = 1'b1;
			if (pri > best_q) begin
				best_n = pri;
				top_n  = {1'b0, cmd.idx};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEV_MAX; i++) begin
				beat_q[i]   <= '0;
				online_q[i] <= '0;
			end
		end else if (cmd.beat && dev_ok) begin
			beat_q[dev_q] <= now_q;
			if (lost_q[dev_q]) begin
				online_q[dev_q] <= now_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_q     <= '1;
			err_q      <= '1;
			derr_q     <= '1;
			best_q     <= '0;
			top_q      <= NO_DEV;
			any_q      <= 1'b0;
			scan_any_q <= 1'b0;
			scan_top_q <= NO_DEV;
		end else begin
			if (cmd.load) begin
				best_q <= '0;
				top_q  <= NO_DEV;
				any_q  <= 1'b0;
			end
			if (cmd.beat && dev_ok) begin
				lost_q[dev_q] <= 1'b0;
				derr_q[dev_q] <= bad_q;
				if (bad_q) begin
					err_q[dev_q] <= 1'b1;
				end
			end
			if (cmd.scan_step) begin
				best_q <= best_n;
				top_q  <= top_n;
				any_q  <= any_n;
				if (en) begin
					if (offline) begin
						// A device already in error keeps its lost flag as is.
						if (!err_q[cmd.idx]) begin
							lost_q[cmd.idx] <= 1'b1;
							err_q[cmd.idx]  <= 1'b1;
						end
					end else if (settling) begin
						lost_q[cmd.idx] <= 1'b0;
						err_q[cmd.idx]  <= 1'b1;
					end else begin
						lost_q[cmd.idx] <= 1'b0;
						err_q[cmd.idx]  <= derr_q[cmd.idx];
					end
				end
			end
			if (cmd.scan_last) begin
				scan_any_q <= any_n;
				scan_top_q <= top_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dev_err_q  <= dev_ok && err_q[dev_q];
			lost_out_q <= lost_q & DEV_MASK;
			err_out_q  <= err_q & DEV_MASK;
			any_out_q  <= scan_any_q;
			top_out_q  <= scan_top_q;
		end
	end

	assign device_error = dev_err_q;
	assign lost_mask    = lost_out_q;
	assign error_mask   = err_out_q;
	assign any_offline  = any_out_q;
	assign top_device   = top_out_q;

endmodule
